[rtl/gic_pkg.sv]
// Shared types and constants of the greedy interval coloring unit.
package gic_pkg;

  localparam int MaxIntervalsDef = 64;
  localparam int TimeBitsDef     = 16;
  localparam int PortTimeW       = 16;
  localparam int ColorLimit      = 64;
  localparam int ColorW          = 6;
  localparam int CountW          = 7;
  localparam int QueueDepth      = 2;

  typedef struct packed {
    logic [PortTimeW-1:0] ibeg;
    logic [PortTimeW-1:0] iend;
    logic                 last;
  } gic_item_t;

endpackage

[rtl/gic_front.sv]
// Request intake: time masking and a two-entry queue toward the back end.
module gic_front import gic_pkg::*; #(
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PortTimeW-1:0] interval_begin_i,
  input  logic [PortTimeW-1:0] interval_end_i,
  input  logic                 last_of_set_i,
  output logic                 q_valid_o,
  output gic_item_t            q_item_o,
  input  logic                 q_pop_i
);

  localparam int TW = (TIME_BITS < PortTimeW) ? TIME_BITS : PortTimeW;
  localparam logic [PortTimeW-1:0] TimeMask = PortTimeW'((64'd1 << TW) - 64'd1);

  gic_item_t  slot_q [QueueDepth];
  gic_item_t  item_in;
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = slot_q[rd_q];

  always_comb begin
    item_in.ibeg = interval_begin_i & TimeMask;
    item_in.iend = interval_end_i & TimeMask;
    item_in.last = last_of_set_i;
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  // payload slots, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/gic_back.sv]
// Coloring engine: stored interval scan, free color pick and result register.
module gic_back import gic_pkg::*; #(
  parameter int MAX_INTERVALS = MaxIntervalsDef,
  parameter int TIME_BITS     = TimeBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  gic_item_t         q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ColorW-1:0] assigned_color_o,
  output logic [CountW-1:0] colors_used_o,
  output logic              overflow_o,
  output logic              set_done_o
);

  localparam int TW = (TIME_BITS < PortTimeW) ? TIME_BITS : PortTimeW;
  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StPick = 2'd2;

  logic [TW-1:0]     begin_mem [MAX_INTERVALS];
  logic [TW-1:0]     end_mem   [MAX_INTERVALS];
  logic [ColorW-1:0] color_mem [MAX_INTERVALS];

  logic [1:0]            state_q, state_d;
  logic [TW-1:0]         ibeg_q, ibeg_d, iend_q, iend_d;
  logic                  last_q, last_d;
  logic [CW-1:0]         issue_q, issue_d;
  logic                  pend_q, pend_d;
  logic [ColorLimit-1:0] forbid_q, forbid_d;
  logic [CW-1:0]         stored_q, stored_d;
  logic [CountW-1:0]     ccount_q, ccount_d;
  logic                  oval_q, oval_d;
  logic [ColorW-1:0]     ocolor_q, ocolor_d;
  logic [CountW-1:0]     oused_q, oused_d;
  logic                  oovf_q, oovf_d;
  logic                  odone_q, odone_d;

  logic [TW-1:0]     rd_beg_q, rd_end_q;
  logic [ColorW-1:0] rd_col_q;
  logic              rd_en, wr_en, hit;

  logic [ColorLimit-1:0] below, allowed, lowest;
  logic [ColorW-1:0]     pick;
  logic                  found, full, refuse, fire;
  logic [ColorW-1:0]     color;
  logic [CountW-1:0]     ccount_next;

  assign rd_en = (state_q == StScan) && (issue_q < stored_q);
  assign hit   = (ibeg_q >= rd_beg_q) && (ibeg_q < rd_end_q);
  assign full  = (stored_q == CW'(MAX_INTERVALS));
  assign fire  = (state_q == StPick) && (!oval_q || !out_stall_i);

  always_comb begin
    for (int c = 0; c < ColorLimit; c++) begin
      below[c] = (CountW'(c) < ccount_q);
    end
    allowed = ~forbid_q & below;
    lowest  = allowed & (~allowed + ColorLimit'(1));
    found   = |allowed;
    pick    = '0;
    for (int c = 0; c < ColorLimit; c++) begin
      if (lowest[c]) begin
        pick = pick | ColorW'(c);
      end
    end
    refuse = full || (!found && (ccount_q == CountW'(ColorLimit)));
    if (refuse) begin
      color = '0;
    end else if (found) begin
      color = pick;
    end else begin
      color = ccount_q[ColorW-1:0];
    end
    ccount_next = ccount_q + CountW'(!found && !refuse);
  end

  assign wr_en = fire && !refuse;

  always_comb begin
    state_d  = state_q;
    ibeg_d   = ibeg_q;
    iend_d   = iend_q;
    last_d   = last_q;
    issue_d  = issue_q;
    pend_d   = 1'b0;
    forbid_d = forbid_q;
    stored_d = stored_q;
    ccount_d = ccount_q;
    oval_d   = oval_q && out_stall_i;
    ocolor_d = ocolor_q;
    oused_d  = oused_q;
    oovf_d   = oovf_q;
    odone_d  = odone_q;
    q_pop_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          ibeg_d   = q_item_i.ibeg[TW-1:0];
          iend_d   = q_item_i.iend[TW-1:0];
          last_d   = q_item_i.last;
          issue_d  = '0;
          forbid_d = '0;
          state_d  = (stored_q == '0 || full) ? StPick : StScan;
        end
      end
      StScan: begin
        if (rd_en) begin
          issue_d = issue_q + CW'(1);
          pend_d  = 1'b1;
        end
        if (pend_q && hit) begin
          forbid_d = forbid_q | (ColorLimit'(1) << rd_col_q);
        end
        if (!rd_en && !pend_q) begin
          state_d = StPick;
        end
      end
      StPick: begin
        if (fire) begin
          oval_d   = 1'b1;
          ocolor_d = color;
          oused_d  = ccount_next;
          oovf_d   = refuse;
          odone_d  = last_q;
          stored_d = stored_q + CW'(!refuse);
          ccount_d = ccount_next;
          if (last_q) begin
            stored_d = '0;
            ccount_d = '0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // interval store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      begin_mem[stored_q[AW-1:0]] <= ibeg_q;
      end_mem[stored_q[AW-1:0]]   <= iend_q;
      color_mem[stored_q[AW-1:0]] <= color;
    end
    if (rd_en) begin
      rd_beg_q <= begin_mem[issue_q[AW-1:0]];
      rd_end_q <= end_mem[issue_q[AW-1:0]];
      rd_col_q <= color_mem[issue_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    ibeg_q   <= ibeg_d;
    iend_q   <= iend_d;
    last_q   <= last_d;
    forbid_q <= forbid_d;
    ocolor_q <= ocolor_d;
    oused_q  <= oused_d;
    oovf_q   <= oovf_d;
    odone_q  <= odone_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      issue_q  <= '0;
      pend_q   <= 1'b0;
      stored_q <= '0;
      ccount_q <= '0;
      oval_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      issue_q  <= issue_d;
      pend_q   <= pend_d;
      stored_q <= stored_d;
      ccount_q <= ccount_d;
      oval_q   <= oval_d;
    end
  end

  assign out_valid_o      = oval_q;
  assign assigned_color_o = ocolor_q;
  assign colors_used_o    = oused_q;
  assign overflow_o       = oovf_q;
  assign set_done_o       = odone_q;

endmodule

[rtl/greedy_interval_coloring_unit.sv]
// Top level of the greedy interval coloring unit.
//   channel   direction  handshake               payload
//   in        request    in_valid_i/in_stall_o   interval_begin_i, interval_end_i, last_of_set_i
//   out       result     out_valid_o/out_stall_i assigned_color_o, colors_used_o, overflow_o,
//                                                set_done_o
// Per request the engine takes it from the queue, reads each stored interval in turn through
// the single-port store, whose read data is registered, compares it, leaves the scan and picks
// the color; the scan is skipped when the store is empty or full.
// Reset clears the queue, the counters and the result valid flag; the store is not cleared.
// A two-entry queue takes requests while the engine works; the result register holds a
// result while out_stall_i is high and the engine scans the next one, picking once it is taken.
module greedy_interval_coloring_unit import gic_pkg::*; #(
  parameter int MAX_INTERVALS = MaxIntervalsDef,
  parameter int TIME_BITS     = TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PortTimeW-1:0] interval_begin_i,
  input  logic [PortTimeW-1:0] interval_end_i,
  input  logic                 last_of_set_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ColorW-1:0]    assigned_color_o,
  output logic [CountW-1:0]    colors_used_o,
  output logic                 overflow_o,
  output logic                 set_done_o
);

  logic      q_valid, q_pop;
  gic_item_t q_item;

  gic_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .interval_begin_i(interval_begin_i),
    .interval_end_i  (interval_end_i),
    .last_of_set_i   (last_of_set_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  gic_back #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .TIME_BITS    (TIME_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .assigned_color_o(assigned_color_o),
    .colors_used_o   (colors_used_o),
    .overflow_o      (overflow_o),
    .set_done_o      (set_done_o)
  );

endmodule

[rtl/gic_checker.sv]
// Port-level checks of the greedy interval coloring unit and their binding.
module gic_checker import gic_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [PortTimeW-1:0] interval_begin_i,
  input logic [PortTimeW-1:0] interval_end_i,
  input logic                 last_of_set_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [ColorW-1:0]    assigned_color_o,
  input logic [CountW-1:0]    colors_used_o,
  input logic                 overflow_o,
  input logic                 set_done_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(interval_begin_i)
      && $stable(interval_end_i) && $stable(last_of_set_i))
    else $error("request changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(assigned_color_o)
      && $stable(colors_used_o) && $stable(overflow_o) && $stable(set_done_o))
    else $error("result changed while stalled");

  a_refused_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> assigned_color_o == '0)
    else $error("refused request carries a color");

  a_color_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !overflow_o |-> CountW'(assigned_color_o) < colors_used_o)
    else $error("assigned color not below color count");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> colors_used_o <= CountW'(ColorLimit))
    else $error("color count above limit");

endmodule

bind greedy_interval_coloring_unit gic_checker u_gic_checker (.*);

[verif/tb.sv]
// Testbench for greedy_interval_coloring_unit: random, mostly sorted sets checked by a scoreboard.
module tb;
  import gic_pkg::*;

  localparam int CycleLimit    = 600000;
  localparam int RequestTarget = 1350;
  localparam logic [PortTimeW-1:0] TimeMask = PortTimeW'((64'd1 << TimeBitsDef) - 64'd1);

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic [CountW-1:0] used;
    logic              ovf;
    logic              done;
  } room_t;

  class room_ledger;
    logic [PortTimeW-1:0] open_at [MaxIntervalsDef];
    logic [PortTimeW-1:0] close_at [MaxIntervalsDef];
    logic [ColorW-1:0]    room_of [MaxIntervalsDef];
    int    held;
    int    rooms;
    int    faults;
    room_t pending_rooms [$];

    function new();
      held   = 0;
      rooms  = 0;
      faults = 0;
    endfunction

    function void book_interval(logic [PortTimeW-1:0] ib, logic [PortTimeW-1:0] ie,
                                logic last);
      logic [PortTimeW-1:0]  nb;
      logic [PortTimeW-1:0]  ne;
      logic [ColorLimit-1:0] taken;
      room_t                 want;
      int                    c;
      nb   = ib & TimeMask;
      ne   = ie & TimeMask;
      want = '0;
      c    = 0;
      want.done = last;
      if (held >= MaxIntervalsDef) begin
        want.ovf = 1'b1;
      end else begin
        taken = '0;
        for (int i = 0; i < held; i++) begin
          if (nb >= open_at[i] && nb < close_at[i]) taken[room_of[i]] = 1'b1;
        end
        while (c < rooms && c < ColorLimit && taken[c]) c++;
        if (c >= rooms) begin
          if (rooms >= ColorLimit) begin
            want.ovf = 1'b1;
            c = 0;
          end else begin
            c = rooms;
            rooms++;
          end
        end
        if (!want.ovf) begin
          open_at[held]  = nb;
          close_at[held] = ne;
          room_of[held]  = ColorW'(c);
          held++;
        end
      end
      want.color = want.ovf ? '0 : ColorW'(c);
      want.used  = CountW'(rooms);
      pending_rooms.push_back(want);
      if (last) begin
        held  = 0;
        rooms = 0;
      end
    endfunction

    function void check_room(room_t got);
      room_t want;
      if (pending_rooms.size() == 0) begin
        faults++;
        $error("result with no request pending: color %0d used %0d overflow %0d done %0d",
               got.color, got.used, got.ovf, got.done);
        return;
      end
      want = pending_rooms.pop_front();
      if (got.color !== want.color) begin
        faults++;
        $error("assigned_color: expected %0d, got %0d", want.color, got.color);
      end
      if (got.used !== want.used) begin
        faults++;
        $error("colors_used: expected %0d, got %0d", want.used, got.used);
      end
      if (got.ovf !== want.ovf) begin
        faults++;
        $error("overflow: expected %0d, got %0d", want.ovf, got.ovf);
      end
      if (got.done !== want.done) begin
        faults++;
        $error("set_done: expected %0d, got %0d", want.done, got.done);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_stall_o;
  logic [PortTimeW-1:0] interval_begin_i = '0;
  logic [PortTimeW-1:0] interval_end_i   = '0;
  logic                 last_of_set_i    = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i      = 1'b0;
  logic [ColorW-1:0]    assigned_color_o;
  logic [CountW-1:0]    colors_used_o;
  logic                 overflow_o;
  logic                 set_done_o;

  room_ledger ledger = new();
  int sent         = 0;
  int results_seen = 0;
  int rest_left    = 0;
  int cycles       = 0;

  greedy_interval_coloring_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .interval_begin_i (interval_begin_i),
    .interval_end_i   (interval_end_i),
    .last_of_set_i    (last_of_set_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .assigned_color_o (assigned_color_o),
    .colors_used_o    (colors_used_o),
    .overflow_o       (overflow_o),
    .set_done_o       (set_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    forever @(negedge clk_i) begin
      out_stall_i <= (rest_left > 0);
      if (rest_left > 0) rest_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      ledger.check_room('{assigned_color_o, colors_used_o, overflow_o, set_done_o});
      results_seen++;
      if (results_seen == 300) rest_left = 600;
      else if ((results_seen / 150) % 3 == 1) rest_left = 0;
      else rest_left = $urandom_range(0, 6);
    end
  end

  task automatic offer_interval(input logic [PortTimeW-1:0] ib, input logic [PortTimeW-1:0] ie,
                                input logic last, input int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    interval_begin_i <= ib;
    interval_end_i   <= ie;
    last_of_set_i    <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    ledger.book_interval(ib, ie, last);
    sent++;
  endtask

  task automatic offer_random_set(input int count);
    logic [16:0]          t;
    logic [PortTimeW-1:0] ib;
    logic [PortTimeW-1:0] ie;
    int                   spread;
    int                   reach;
    int                   k;
    bit                   shuffled;
    bit                   quiet;
    t = ($urandom_range(0, 3) == 0) ? 17'(65535 - $urandom_range(0, 100))
                                    : 17'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 4;
      2: spread = 60;
      default: spread = 3000;
    endcase
    case ($urandom_range(0, 3))
      0: reach = 3;
      1: reach = 40;
      2: reach = 500;
      default: reach = 65535;
    endcase
    shuffled = ($urandom_range(0, 9) == 0);
    quiet    = ($urandom_range(0, 3) == 0);
    for (k = 0; k < count; k++) begin
      if (shuffled) begin
        ib = PortTimeW'($urandom_range(0, 65535));
      end else begin
        t = t + 17'($urandom_range(0, spread));
        if (t > 17'd65535) t = 17'd65535;
        ib = t[PortTimeW-1:0];
      end
      case ($urandom_range(0, 19))
        0: ie = ib - PortTimeW'($urandom_range(0, 5));
        1: ie = '1;
        default: ie = ib + PortTimeW'($urandom_range(1, reach));
      endcase
      offer_interval(ib, ie, k == count - 1, quiet ? 0 : $urandom_range(0, 6));
    end
  endtask

  initial begin
    int k;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    offer_interval(16'd0, 16'hFFFF, 1'b0, 0);
    offer_interval(16'd0, 16'd1, 1'b0, 0);
    offer_interval(16'd0, 16'd100, 1'b0, 1);
    offer_interval(16'd1, 16'd5, 1'b0, 0);
    offer_interval(16'd100, 16'd200, 1'b0, 3);
    offer_interval(16'hFFFF, 16'hFFFF, 1'b0, 0);
    offer_interval(16'hFFFF, 16'd0, 1'b1, 0);
    offer_interval(16'h5555, 16'hAAAA, 1'b1, 2);

    // fill the store with mutually overlapping intervals, then overrun it
    for (k = 0; k < MaxIntervalsDef + 2; k++) begin
      offer_interval(16'd0, 16'hFFFF, k == MaxIntervalsDef + 1, $urandom_range(0, 2));
    end

    while (sent < RequestTarget) begin
      offer_random_set(($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
                                                     : $urandom_range(1, 12));
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (ledger.pending_rooms.size() != 0) @(posedge clk_i);
    repeat (MaxIntervalsDef + 8) @(posedge clk_i);
    if (ledger.faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/gic_pkg.sv
rtl/gic_front.sv
rtl/gic_back.sv
rtl/greedy_interval_coloring_unit.sv
rtl/gic_checker.sv
verif/tb.sv
